FILE: design/skbb_pkg.sv
// Shared types and constants for the skip-bad-block page translator.
package skbb_pkg;

   // Field widths fixed by the interface
   localparam int PAGE_W     = 22;
   localparam int BLK_W      = 12;
   localparam int CNT_W      = 13;
   localparam int SHIFT_W    = 4;
   localparam int OFS_W      = 10;
   localparam int STATUS_W   = 2;
   localparam int ESTATE_W   = 2;
   localparam int ENTRY_W    = 3;
   localparam int CURR_W     = PAGE_W + 1;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 13;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 40;

   // Largest shift honored, and the saturation point of block numbers
   localparam logic [SHIFT_W-1:0] SHIFT_MAX = 4'd10;
   localparam logic [CNT_W-1:0]   BLK_SAT   = 13'h1FFF;

   // Command codes carried on req_tuser
   localparam logic CMD_WRITE     = 1'b0;
   localparam logic CMD_TRANSLATE = 1'b1;

   // Table entry states
   localparam logic [ESTATE_W-1:0] ST_UNKNOWN = 2'd0;
   localparam logic [ESTATE_W-1:0] ST_GOOD    = 2'd1;
   localparam logic [ESTATE_W-1:0] ST_ERASED  = 2'd2;
   localparam logic [ESTATE_W-1:0] ST_BAD     = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 2'd2;

   // Configuration register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_PAGES_LOG2  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHIP_BLOCKS = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_BYPASS      = 2'd2;

   // Configuration reset values
   localparam logic [SHIFT_W-1:0] PAGES_LOG2_RST  = 4'd6;
   localparam logic [CNT_W-1:0]   CHIP_BLOCKS_RST = 13'd4096;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;
      logic capture;
      logic write;
      logic setup;
      logic walk;
      logic emit;
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic is_write;
      logic clear_last;
      logic walk_end;
      logic out_free;
   } dp_status_type;

endpackage

FILE: design/skbb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module skbb_ram #(
   parameter int WIDTH = 3,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/skbb_ctrl.sv
// Sequencer for table clearing, entry writes and translation walks.
module skbb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  skbb_pkg::dp_status_type status,
   output skbb_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_WRITE = 3'd2;
   localparam logic [2:0] S_SETUP = 3'd3;
   localparam logic [2:0] S_PRIME = 3'd4;
   localparam logic [2:0] S_WALK  = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = S_SETUP;
            end
         end
         S_SETUP: begin
            if (status.is_write) begin
               state_in = S_WRITE;
            end else begin
               cmd.setup = 1'b1;
               state_in  = S_PRIME;
            end
         end
         S_WRITE: begin
            cmd.write = 1'b1;
            state_in  = S_DONE;
         end
         S_PRIME: begin
            state_in = S_WALK;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_end) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: design/skbb_datapath.sv
// Block table, configuration registers, walk counters and result registers.
module skbb_datapath #(
   parameter int MAX_BLOCKS = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  skbb_pkg::ctrl_cmd_type               cmd,
   output skbb_pkg::dp_status_type              status,
   input  logic [skbb_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                 req_tuser,
   input  logic                                 csr_we,
   input  logic [skbb_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [skbb_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [skbb_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int AW     = $clog2(MAX_BLOCKS);
   localparam int PAGE_W = skbb_pkg::PAGE_W;
   localparam int CURR_W = skbb_pkg::CURR_W;
   localparam int CNT_W  = skbb_pkg::CNT_W;
   localparam int BLK_W  = skbb_pkg::BLK_W;
   localparam int OFS_W  = skbb_pkg::OFS_W;
   localparam int STS_W  = skbb_pkg::STATUS_W;

   // Configuration registers
   logic [skbb_pkg::SHIFT_W-1:0] pages_log2_ff;
   logic [CNT_W-1:0]             chip_blocks_ff;
   logic                         bypass_ff;

   // Captured request fields
   logic                            cmd_ff;
   logic [PAGE_W-1:0]               page_ff;
   logic                            use_part_ff;
   logic [BLK_W-1:0]                pbase_ff;
   logic [CNT_W-1:0]                pcount_ff;
   logic [BLK_W-1:0]                eblk_ff;
   logic [skbb_pkg::ESTATE_W-1:0]   estate_ff;
   logic                            ersv_ff;

   // Walk state
   logic [CURR_W-1:0] curr_ff;
   logic [CNT_W-1:0]  end_ff;
   logic [PAGE_W-1:0] target_ff;
   logic [PAGE_W-1:0] logical_ff;
   logic [OFS_W-1:0]  offset_ff;
   logic [AW-1:0]     clr_ff;

   // Result and output registers
   logic [CNT_W-1:0] res_phys_ff;
   logic [CNT_W-1:0] res_end_ff;
   logic [OFS_W-1:0] res_ofs_ff;
   logic [STS_W-1:0] res_sts_ff;
   logic             rsp_valid_ff;
   logic [skbb_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   // Derived values
   logic [skbb_pkg::SHIFT_W-1:0] shift;
   logic [CNT_W-1:0]             chip_eff;
   logic [PAGE_W-1:0]            page_block;
   logic [OFS_W-1:0]             page_ofs;
   logic [CURR_W-1:0]            bypass_sum;
   logic                         entry_in_range;

   // Memory ports
   logic                           mem_we;
   logic [AW-1:0]                  mem_waddr;
   logic [skbb_pkg::ENTRY_W-1:0]   mem_wdata;
   logic [AW-1:0]                  mem_raddr;
   logic [skbb_pkg::ENTRY_W-1:0]   mem_rdata;

   // Walk step decode
   logic             walk_cont;
   logic             walk_end;
   logic             walk_adv;
   logic             walk_count;
   logic [STS_W-1:0] walk_sts;
   logic [CURR_W-1:0] curr_next;

   assign shift    = (pages_log2_ff > skbb_pkg::SHIFT_MAX) ? skbb_pkg::SHIFT_MAX
                                                           : pages_log2_ff;
   assign chip_eff = (32'(chip_blocks_ff) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                        : chip_blocks_ff;
   assign page_block     = page_ff >> shift;
   assign page_ofs       = OFS_W'(page_ff & ~({PAGE_W{1'b1}} << shift));
   assign bypass_sum     = CURR_W'(pbase_ff) + CURR_W'(page_block);
   assign entry_in_range = (32'(eblk_ff) < MAX_BLOCKS);
   assign curr_next      = curr_ff + CURR_W'(1);

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pages_log2_ff  <= skbb_pkg::PAGES_LOG2_RST;
         chip_blocks_ff <= skbb_pkg::CHIP_BLOCKS_RST;
         bypass_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_addr)
            skbb_pkg::CSR_PAGES_LOG2:  pages_log2_ff  <= csr_wdata[skbb_pkg::SHIFT_W-1:0];
            skbb_pkg::CSR_CHIP_BLOCKS: chip_blocks_ff <= csr_wdata;
            skbb_pkg::CSR_BYPASS:      bypass_ff      <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff      <= req_tuser;
         page_ff     <= req_tdata[21:0];
         use_part_ff <= req_tdata[22];
         pbase_ff    <= req_tdata[34:23];
         pcount_ff   <= req_tdata[47:35];
         eblk_ff     <= req_tdata[59:48];
         estate_ff   <= req_tdata[61:60];
         ersv_ff     <= req_tdata[62];
      end
   end

   // Sweep the table to unknown after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // Table write: clearing sweep or entry command
   assign mem_we    = cmd.clear || (cmd.write && entry_in_range);
   assign mem_waddr = cmd.clear ? clr_ff : AW'(eblk_ff);
   assign mem_wdata = cmd.clear ? '0 : {ersv_ff, estate_ff};
   // Prefetch the next block while the current one is judged
   assign mem_raddr = cmd.walk ? AW'(curr_next) : AW'(curr_ff);

   skbb_ram #(
      .WIDTH (skbb_pkg::ENTRY_W),
      .DEPTH (MAX_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Judge one table entry per cycle
   always_comb begin
      walk_cont  = (curr_ff < CURR_W'(end_ff)) && (logical_ff < target_ff);
      walk_end   = 1'b0;
      walk_adv   = 1'b0;
      walk_count = 1'b0;
      walk_sts   = skbb_pkg::STATUS_OK;
      if (!walk_cont) begin
         walk_end = 1'b1;
         walk_sts = (logical_ff == target_ff) ? skbb_pkg::STATUS_OK
                                              : skbb_pkg::STATUS_RANGE;
      end else if (curr_ff >= CURR_W'(chip_eff)) begin
         walk_end = 1'b1;
         walk_sts = skbb_pkg::STATUS_UNKNOWN;
      end else if (mem_rdata[2] || (mem_rdata[1:0] == skbb_pkg::ST_BAD)) begin
         walk_adv = 1'b1;
      end else if (mem_rdata[1:0] == skbb_pkg::ST_UNKNOWN) begin
         walk_end = 1'b1;
         walk_sts = skbb_pkg::STATUS_UNKNOWN;
      end else begin
         walk_adv   = 1'b1;
         walk_count = 1'b1;
      end
   end

   // Load and advance the walk counters
   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         if (use_part_ff) begin
            curr_ff   <= bypass_ff ? bypass_sum : CURR_W'(pbase_ff);
            end_ff    <= CNT_W'(pbase_ff) + pcount_ff;
            target_ff <= bypass_ff ? '0 : page_block;
         end else begin
            curr_ff   <= CURR_W'(page_block);
            end_ff    <= chip_eff;
            target_ff <= '0;
         end
         logical_ff <= '0;
         offset_ff  <= page_ofs;
      end else if (cmd.walk) begin
         if (walk_adv) begin
            curr_ff <= curr_next;
         end
         if (walk_count) begin
            logical_ff <= logical_ff + PAGE_W'(1);
         end
      end
   end

   // Hold the finished result
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         res_phys_ff <= '0;
         res_end_ff  <= '0;
         res_ofs_ff  <= '0;
         res_sts_ff  <= skbb_pkg::STATUS_OK;
      end else if (cmd.walk && walk_end) begin
         res_sts_ff <= walk_sts;
         if (walk_sts == skbb_pkg::STATUS_OK) begin
            res_phys_ff <= (curr_ff > CURR_W'(skbb_pkg::BLK_SAT)) ? skbb_pkg::BLK_SAT
                                                                 : curr_ff[CNT_W-1:0];
            res_end_ff  <= end_ff;
            res_ofs_ff  <= offset_ff;
         end else begin
            res_phys_ff <= '0;
            res_end_ff  <= '0;
            res_ofs_ff  <= '0;
         end
      end
   end

   // Output register: hold the beat until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= {2'b00, res_sts_ff, res_ofs_ff, res_end_ff, res_phys_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign status.is_write   = (cmd_ff == skbb_pkg::CMD_WRITE);
   assign status.clear_last = (clr_ff == AW'(MAX_BLOCKS - 1));
   assign status.walk_end   = walk_end;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

endmodule

FILE: design/skip_bad_block_page_translator.sv
// Top level of the skip-bad-block NAND page translator.
// Usage:
//   req_* carries one command beat. req_tuser selects the command: 0 writes
//   one bad-block table entry, 1 translates a page. Every beat gives exactly
//   one rsp_* beat (all zero for a table write).
//   csr_* writes configuration: index 0 pages-per-block log2, 1 chip block
//   count, 2 bypass. Write it only while no command is in flight.
// Sequence:
//   A table write passes through the setup, write and done states; a
//   translation through setup, prime, walk and done, where the walk steps
//   over blocks (none in bypass or without a partition). The walk reads one
//   table entry per cycle. One command is in flight at a time; the next is
//   taken once the response has been loaded into the output register.
// Reset:
//   Control and configuration registers return to their defaults and a
//   clearing pass writes every table entry to unknown, not reserved, with
//   req_tready low. CSR writes are taken throughout.
// Stall:
//   The response waits in an output register; one new command is accepted
//   meanwhile, and its response waits until the held one is taken.
module skip_bad_block_page_translator #(
   parameter int MAX_BLOCKS = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // tdata: page[21:0], use_partition[22], part_base[34:23],
   //        part_block_count[47:35], entry_block[59:48], entry_state[61:60],
   //        entry_reserved[62], zero pad[63]
   input  logic [skbb_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser: cmd[0]
   input  logic                                req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // tdata: phys_block[12:0], region_end[25:13], page_in_block[35:26],
   //        status[37:36], zero pad[39:38]
   output logic [skbb_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [skbb_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [skbb_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   skbb_pkg::ctrl_cmd_type  ctrl_cmd;
   skbb_pkg::dp_status_type dp_status;

   skbb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (ctrl_cmd)
   );

   skbb_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (ctrl_cmd),
      .status     (dp_status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: bench/tb_skip_bad_block_page_translator.sv
// Self-checking bench for the skip-bad-block page translator: table writes, walks, bypass.
`timescale 1ns / 1ps

module tb_skip_bad_block_page_translator;

   localparam int NBLK        = 4096;
   localparam int STALL_LIMIT = 20000;
   localparam int LONG_HOLD   = 300;
   localparam int PHASES      = 7;
   localparam int PHASE_BEATS = 13;

   // Widths and codes taken from the shared package
   localparam int PAGE_W     = skbb_pkg::PAGE_W;
   localparam int BLK_W      = skbb_pkg::BLK_W;
   localparam int CNT_W      = skbb_pkg::CNT_W;
   localparam int ESTATE_W   = skbb_pkg::ESTATE_W;
   localparam int OFS_W      = skbb_pkg::OFS_W;
   localparam int STATUS_W   = skbb_pkg::STATUS_W;
   localparam int SHIFT_W    = skbb_pkg::SHIFT_W;
   localparam int CSR_ADDR_W = skbb_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = skbb_pkg::CSR_DATA_W;
   localparam int REQ_DATA_W = skbb_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = skbb_pkg::RSP_DATA_W;

   localparam logic [SHIFT_W-1:0]    SHIFT_MAX       = skbb_pkg::SHIFT_MAX;
   localparam logic [CNT_W-1:0]      BLK_SAT         = skbb_pkg::BLK_SAT;
   localparam logic                  CMD_WRITE       = skbb_pkg::CMD_WRITE;
   localparam logic                  CMD_TRANSLATE   = skbb_pkg::CMD_TRANSLATE;
   localparam logic [ESTATE_W-1:0]   ST_UNKNOWN      = skbb_pkg::ST_UNKNOWN;
   localparam logic [ESTATE_W-1:0]   ST_GOOD         = skbb_pkg::ST_GOOD;
   localparam logic [ESTATE_W-1:0]   ST_ERASED       = skbb_pkg::ST_ERASED;
   localparam logic [ESTATE_W-1:0]   ST_BAD          = skbb_pkg::ST_BAD;
   localparam logic [STATUS_W-1:0]   STATUS_OK       = skbb_pkg::STATUS_OK;
   localparam logic [STATUS_W-1:0]   STATUS_RANGE    = skbb_pkg::STATUS_RANGE;
   localparam logic [STATUS_W-1:0]   STATUS_UNKNOWN  = skbb_pkg::STATUS_UNKNOWN;
   localparam logic [CSR_ADDR_W-1:0] CSR_PAGES_LOG2  = skbb_pkg::CSR_PAGES_LOG2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CHIP_BLOCKS = skbb_pkg::CSR_CHIP_BLOCKS;
   localparam logic [CSR_ADDR_W-1:0] CSR_BYPASS      = skbb_pkg::CSR_BYPASS;
   localparam logic [SHIFT_W-1:0]    PAGES_LOG2_RST  = skbb_pkg::PAGES_LOG2_RST;
   localparam logic [CNT_W-1:0]      CHIP_BLOCKS_RST = skbb_pkg::CHIP_BLOCKS_RST;

   // One command beat, split into its fields
   typedef struct packed {
      logic                cmd;
      logic [PAGE_W-1:0]   page;
      logic                use_part;
      logic [BLK_W-1:0]    pbase;
      logic [CNT_W-1:0]    pcount;
      logic [BLK_W-1:0]    eblk;
      logic [ESTATE_W-1:0] estate;
      logic                erv;
   } page_cmd_type;

   // One response beat, split into its fields
   typedef struct packed {
      logic [CNT_W-1:0]    phys;
      logic [CNT_W-1:0]    end_blk;
      logic [OFS_W-1:0]    pib;
      logic [STATUS_W-1:0] status;
   } page_map_type;

   // Directed plan entry: a register write or a command beat
   typedef struct packed {
      logic                  is_csr;
      logic [CSR_ADDR_W-1:0] csr_idx;
      logic [CSR_DATA_W-1:0] csr_val;
      logic                  typed;
      page_cmd_type          cmd;
      page_map_type          ans;
   } plan_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Shadow of the block: table entries and configuration
   logic [ESTATE_W-1:0] blk_state [0:NBLK-1];
   logic                blk_reserved [0:NBLK-1];
   logic [SHIFT_W-1:0]  cfg_shift = PAGES_LOG2_RST;
   logic [CNT_W-1:0]    cfg_chip = CHIP_BLOCKS_RST;
   logic                cfg_bypass = 1'b0;

   page_map_type answers_due [$];
   int        beats_sent = 0;
   int        fails = 0;
   bit        idle_on = 1'b1;
   bit        hold_long_req = 1'b0;

   always #5 clock = ~clock;

   skip_bad_block_page_translator #(.MAX_BLOCKS(NBLK)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   function automatic page_cmd_type xlate_cmd(int page, int up, int pb, int pc);
      page_cmd_type c;
      c          = '0;
      c.cmd      = CMD_TRANSLATE;
      c.page     = page[PAGE_W-1:0];
      c.use_part = up[0];
      c.pbase    = pb[BLK_W-1:0];
      c.pcount   = pc[CNT_W-1:0];
      return c;
   endfunction

   function automatic page_cmd_type entry_cmd(int blk, int st, int rsv);
      page_cmd_type c;
      c        = '0;
      c.cmd    = CMD_WRITE;
      c.eblk   = blk[BLK_W-1:0];
      c.estate = st[ESTATE_W-1:0];
      c.erv    = rsv[0];
      return c;
   endfunction

   function automatic page_map_type mapped(int phys, int endb, int pib,
                                           logic [STATUS_W-1:0] st);
      page_map_type m;
      m.phys    = phys[CNT_W-1:0];
      m.end_blk = endb[CNT_W-1:0];
      m.pib     = pib[OFS_W-1:0];
      m.status  = st;
      return m;
   endfunction

   function automatic plan_row_type known(page_cmd_type c, page_map_type a);
      plan_row_type r;
      r       = '0;
      r.typed = 1'b1;
      r.cmd   = c;
      r.ans   = a;
      return r;
   endfunction

   function automatic plan_row_type checked(page_cmd_type c);
      plan_row_type r;
      r     = '0;
      r.cmd = c;
      return r;
   endfunction

   function automatic plan_row_type csr_row(logic [CSR_ADDR_W-1:0] idx, int val);
      plan_row_type r;
      r         = '0;
      r.is_csr  = 1'b1;
      r.csr_idx = idx;
      r.csr_val = val[CSR_DATA_W-1:0];
      return r;
   endfunction

   function automatic int shift_used();
      return (cfg_shift > SHIFT_MAX) ? int'(SHIFT_MAX) : int'(cfg_shift);
   endfunction

   function automatic logic [CNT_W-1:0] sat_blk(int v);
      return (v > int'(BLK_SAT)) ? BLK_SAT : v[CNT_W-1:0];
   endfunction

   // Apply one command to the shadow state and work out the response it earns
   function automatic page_map_type map_page(page_cmd_type c);
      page_map_type m;
      int sh, chip, pblk, ofs, base, lim, target, curr, logical;
      m = '0;
      if (c.cmd == CMD_WRITE) begin
         blk_state[c.eblk]    = c.estate;
         blk_reserved[c.eblk] = c.erv;
         return m;
      end
      sh   = shift_used();
      chip = (cfg_chip > NBLK) ? NBLK : int'(cfg_chip);
      pblk = int'(c.page) >> sh;
      ofs  = int'(c.page) & ((1 << sh) - 1);
      if (c.use_part) begin
         base   = int'(c.pbase);
         lim    = int'(c.pbase) + int'(c.pcount);
         target = pblk;
      end else begin
         base   = pblk;
         lim    = chip;
         target = 0;
      end
      // Bypass: plain arithmetic, no table lookup
      if (cfg_bypass) begin
         m.phys    = sat_blk(c.use_part ? int'(c.pbase) + pblk : pblk);
         m.end_blk = sat_blk(lim);
         m.pib     = ofs[OFS_W-1:0];
         return m;
      end
      // Walk the table, counting usable blocks until the logical block is reached
      curr    = base;
      logical = 0;
      while (curr < lim && logical < target) begin
         if (curr >= chip) begin
            m.status = STATUS_UNKNOWN;
            return m;
         end
         if (blk_reserved[curr]) begin
            curr++;
         end else if (blk_state[curr] == ST_UNKNOWN) begin
            m.status = STATUS_UNKNOWN;
            return m;
         end else if (blk_state[curr] == ST_BAD) begin
            curr++;
         end else begin
            logical++;
            curr++;
         end
      end
      if (logical != target) begin
         m.status = STATUS_RANGE;
         return m;
      end
      m.phys    = sat_blk(curr);
      m.end_blk = sat_blk(lim);
      m.pib     = ofs[OFS_W-1:0];
      return m;
   endfunction

   function automatic void check_field(string what, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fails++;
      end
   endfunction

   // Offer one command beat, hold until taken, then log the response it earns
   task automatic push_beat(input page_cmd_type c, input logic typed,
                            input page_map_type typed_ans);
      page_map_type m;
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c.cmd;
      req_tdata  <= {1'b0, c.erv, c.estate, c.eblk, c.pcount, c.pbase, c.use_part, c.page};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      m = map_page(c);
      answers_due.push_back(typed ? typed_ans : m);
      beats_sent++;
   endtask

   // Drain outstanding commands, then write one register
   task automatic set_register(input logic [CSR_ADDR_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_PAGES_LOG2:  cfg_shift  = val[SHIFT_W-1:0];
         CSR_CHIP_BLOCKS: cfg_chip   = val[CNT_W-1:0];
         CSR_BYPASS:      cfg_bypass = val[0];
         default: ;
      endcase
   endtask

   // Response side: check each beat, stall in random bursts or on request
   initial begin : rsp_sink
      int           hold;
      page_map_type want;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (answers_due.size() == 0) begin
               $display("%0t: response beat with nothing outstanding, expected none, actual %h",
                        $time, rsp_tdata);
               fails++;
            end else begin
               want = answers_due.pop_front();
               check_field("phys_block", int'(want.phys), int'(rsp_tdata[12:0]));
               check_field("region_end", int'(want.end_blk), int'(rsp_tdata[25:13]));
               check_field("page_in_block", int'(want.pib), int'(rsp_tdata[35:26]));
               check_field("status", int'(want.status), int'(rsp_tdata[37:36]));
            end
         end
         if (hold_long_req) begin
            hold_long_req = 1'b0;
            hold = LONG_HOLD;
         end else if (hold == 0 && idle_on && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 14);
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Abort when nothing moves on either side for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      plan_row_type plan [$];
      page_cmd_type c;
      int ph_shift [PHASES];
      int ph_chip [PHASES];
      int ph_bypass [PHASES];
      int p, j, k, n, b, tgt, pc, sh, st, rsv, phase_end;
      int sh_v, chip_v, byp_v;
      logic [31:0] pg;

      ph_shift  = '{6, 1, 10, 4, 0, 0, 3};
      ph_chip   = '{4096, 1, 4096, 300, 8191, 0, 4096};
      ph_bypass = '{0, 0, 1, 0, 0, 0, 0};
      for (j = 0; j < NBLK; j++) begin
         blk_state[j]    = ST_UNKNOWN;
         blk_reserved[j] = 1'b0;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, then a small hand-built region, then config corners
      plan.push_back(known(xlate_cmd(0, 0, 0, 0), mapped(0, 4096, 0, STATUS_OK)));
      plan.push_back(known(xlate_cmd(22'h3FFFFF, 0, 4095, 4096),
                           mapped(8191, 4096, 63, STATUS_OK)));
      plan.push_back(known(xlate_cmd(64, 1, 0, 10), mapped(0, 0, 0, STATUS_UNKNOWN)));
      plan.push_back(known(entry_cmd(0, ST_GOOD, 0), mapped(0, 0, 0, STATUS_OK)));
      plan.push_back(known(entry_cmd(1, ST_BAD, 0), mapped(0, 0, 0, STATUS_OK)));
      plan.push_back(known(entry_cmd(2, ST_GOOD, 1), mapped(0, 0, 0, STATUS_OK)));
      plan.push_back(known(entry_cmd(3, ST_ERASED, 0), mapped(0, 0, 0, STATUS_OK)));
      plan.push_back(known(entry_cmd(4095, ST_BAD, 1), mapped(0, 0, 0, STATUS_OK)));
      plan.push_back(checked(xlate_cmd(2 * 64 + 5, 1, 0, 8)));
      plan.push_back(known(xlate_cmd(3 * 64, 1, 0, 4), mapped(0, 0, 0, STATUS_RANGE)));
      plan.push_back(checked(xlate_cmd(0, 1, 5, 0)));
      plan.push_back(known(xlate_cmd(64, 1, 5, 0), mapped(0, 0, 0, STATUS_RANGE)));
      // walk runs off the end of the chip
      plan.push_back(known(xlate_cmd(64, 1, 4095, 4096), mapped(0, 0, 0, STATUS_UNKNOWN)));
      plan.push_back(known(xlate_cmd(22'h3F, 1, 4095, 4096),
                           mapped(4095, 8191, 63, STATUS_OK)));
      plan.push_back(csr_row(CSR_BYPASS, 1));
      plan.push_back(known(xlate_cmd(22'h3FFFFF, 1, 4095, 4096),
                           mapped(8191, 8191, 63, STATUS_OK)));
      plan.push_back(checked(xlate_cmd(22'h2A5A5A, 0, 0, 0)));
      // oversized shift and chip count clamp
      plan.push_back(csr_row(CSR_BYPASS, 0));
      plan.push_back(csr_row(CSR_PAGES_LOG2, 15));
      plan.push_back(csr_row(CSR_CHIP_BLOCKS, 8191));
      plan.push_back(known(xlate_cmd(22'h3FFFFF, 0, 0, 0),
                           mapped(4095, 4096, 1023, STATUS_OK)));
      plan.push_back(known(entry_cmd(4094, ST_GOOD, 0), mapped(0, 0, 0, STATUS_OK)));
      plan.push_back(checked(xlate_cmd(1024, 1, 4094, 2)));
      // empty chip: plain start passes through, any walk aborts
      plan.push_back(csr_row(CSR_PAGES_LOG2, 0));
      plan.push_back(csr_row(CSR_CHIP_BLOCKS, 0));
      plan.push_back(checked(xlate_cmd(5, 0, 0, 0)));
      plan.push_back(known(xlate_cmd(1, 1, 0, 3), mapped(0, 0, 0, STATUS_UNKNOWN)));
      plan.push_back(checked(xlate_cmd(0, 1, 7, 3)));
      plan.push_back(known(entry_cmd(6, ST_UNKNOWN, 1), mapped(0, 0, 0, STATUS_OK)));

      foreach (plan[i]) begin
         if (plan[i].is_csr) set_register(plan[i].csr_idx, plan[i].csr_val);
         else push_beat(plan[i].cmd, plan[i].typed, plan[i].ans);
      end

      // Random phases, one register setting each; the last runs without idling
      for (p = 0; p < PHASES; p++) begin
         if (p == 5) begin
            sh_v   = $urandom_range(0, 15);
            chip_v = $urandom_range(1, 8191);
            byp_v  = $urandom_range(0, 1);
         end else begin
            sh_v   = ph_shift[p];
            chip_v = ph_chip[p];
            byp_v  = ph_bypass[p];
         end
         idle_on = (p != PHASES - 1);
         set_register(CSR_PAGES_LOG2, sh_v[CSR_DATA_W-1:0]);
         set_register(CSR_CHIP_BLOCKS, chip_v[CSR_DATA_W-1:0]);
         set_register(CSR_BYPASS, byp_v[CSR_DATA_W-1:0]);
         // let the block fill up behind a long response stall
         if (p == 3) hold_long_req = 1'b1;
         phase_end = beats_sent + PHASE_BEATS;
         while (beats_sent < phase_end) begin
            if ($urandom_range(0, 9) < 7) begin
               // Build a short region of entries, then translate pages inside it
               b  = $urandom_range(0, NBLK - 1);
               k  = $urandom_range(1, 12);
               sh = shift_used();
               for (j = 0; j < k; j++) begin
                  st  = $urandom_range(0, 15);
                  st  = (st == 0) ? ST_UNKNOWN : (st < 3) ? ST_BAD :
                        (st < 10) ? ST_GOOD : ST_ERASED;
                  rsv = int'($urandom_range(0, 7) == 0);
                  push_beat(entry_cmd(b + j, st, rsv), 1'b0, '0);
               end
               n = $urandom_range(1, 3);
               for (j = 0; j < n; j++) begin
                  tgt = $urandom_range(0, k + 1);
                  pc  = $urandom_range(0, k + 2);
                  pg  = (tgt << sh) | ($urandom & ((1 << sh) - 1));
                  push_beat(xlate_cmd(pg, 1, b, pc), 1'b0, '0);
               end
            end else begin
               // Noise: every field random
               c.cmd      = 1'($urandom_range(0, 1));
               pg         = $urandom;
               c.page     = pg[PAGE_W-1:0];
               c.use_part = 1'($urandom_range(0, 1));
               pg         = $urandom;
               c.pbase    = pg[BLK_W-1:0];
               c.pcount   = CNT_W'($urandom_range(0, NBLK));
               pg         = $urandom;
               c.eblk     = pg[BLK_W-1:0];
               c.estate   = ESTATE_W'($urandom_range(0, 3));
               c.erv      = 1'($urandom_range(0, 1));
               push_beat(c, 1'b0, '0);
            end
         end
      end

      // Drain, settle, report
      req_tvalid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fails == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
